/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // default configuration
  localparam int DepthDefault    = 16;
  localparam int ItemWDefault    = 32;
  localparam int PriWDefault     = 16;

  // fixed field widths of the words on the ports
  localparam int ItemFieldW  = 32;
  localparam int PriFieldW   = 16;
  localparam int CountFieldW = 5;

  // request codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // request word
  typedef struct packed {
    logic                  opcode;
    logic [ItemFieldW-1:0] item_value;
    logic [PriFieldW-1:0]  priority_req;
  } spq_in_t;

  // result word
  typedef struct packed {
    logic [1:0]             status;
    logic [ItemFieldW-1:0]  removed_item;
    logic [PriFieldW-1:0]   removed_priority;
    logic                   is_empty;
    logic [CountFieldW-1:0] entry_count;
  } spq_out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } spq_ctl_t;

endpackage

/* hw/rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, keeps it, takes the new
// entry, or takes a neighbor's entry when the chain shifts.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int PW = PriWDefault,
  parameter int IW = ItemWDefault
) (
  input  logic          clk,
  input  logic          rst_n,
  input  spq_ctl_t      ctl,
  input  logic [PW-1:0] new_pri,
  input  logic [IW-1:0] new_item,
  input  logic          prev_valid,
  input  logic          prev_le,
  input  logic [PW-1:0] prev_pri,
  input  logic [IW-1:0] prev_item,
  input  logic          next_valid,
  input  logic [PW-1:0] next_pri,
  input  logic [IW-1:0] next_item,
  output logic          valid,
  output logic          le,
  output logic [PW-1:0] pri,
  output logic [IW-1:0] item
);

  logic          valid_r, valid_nxt;
  logic [PW-1:0] pri_r, pri_nxt;
  logic [IW-1:0] item_r, item_nxt;

  // entry here stays ahead of the new one
  assign le = valid_r && (pri_r <= new_pri);

  // next slot contents
  always_comb begin
    valid_nxt = valid_r;
    pri_nxt   = pri_r;
    item_nxt  = item_r;
    if (ctl.rem_en) begin
      valid_nxt = next_valid;
      pri_nxt   = next_pri;
      item_nxt  = next_item;
    end else if (ctl.ins_en && !le) begin
      if (prev_le) begin
        valid_nxt = 1'b1;
        pri_nxt   = new_pri;
        item_nxt  = new_item;
      end else begin
        valid_nxt = prev_valid;
        pri_nxt   = prev_pri;
        item_nxt  = prev_item;
      end
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    pri_r  <= pri_nxt;
    item_r <= item_nxt;
  end

  assign valid = valid_r;
  assign pri   = pri_r;
  assign item  = item_r;

endmodule

/* hw/rtl/sorted_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept as a sorted chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_word carry requests: insert (item, priority) or
//   remove the lowest-priority entry. Equal priorities leave in arrival order.
//   out_valid/out_stall/out_word carry one result word per request: status,
//   the removed entry (zero unless removed), the empty flag and the count.
//   Every slot compares its priority with the new one in parallel and the
//   chain shifts right on insert or left on remove when a request is
//   accepted; the result appears in the output register in the cycle after
//   acceptance. One request per cycle is sustained while the receiver takes
//   results. An insert into a full queue is dropped with status full; a
//   remove on an empty queue changes nothing and reports empty.
//   While a result waits under out_stall, in_stall is raised and no further
//   request is taken. Reset (rst_n low, synchronous) empties the queue and
//   drops any pending result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH          = DepthDefault,
  parameter int ITEM_WIDTH     = ItemWDefault,
  parameter int PRIORITY_WIDTH = PriWDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  spq_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output spq_out_t out_word
);

  // stored widths never exceed the port fields
  localparam int IW = (ITEM_WIDTH < ItemFieldW) ? ITEM_WIDTH : ItemFieldW;
  localparam int PW = (PRIORITY_WIDTH < PriFieldW) ? PRIORITY_WIDTH : PriFieldW;
  localparam int CW = $clog2(DEPTH + 1);

  logic             accept;
  logic             full, empty;
  logic [CW-1:0]    count_r, count_nxt;
  spq_ctl_t         ctl;
  logic [PW-1:0]    new_pri;
  logic [IW-1:0]    new_item;
  logic [DEPTH-1:0] c_valid, c_le;
  logic [PW-1:0]    c_pri  [DEPTH];
  logic [IW-1:0]    c_item [DEPTH];
  logic             out_valid_r;
  spq_out_t         out_word_r, out_word_nxt;

  // handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign new_pri  = in_word.priority_req[PW-1:0];
  assign new_item = in_word.item_value[IW-1:0];

  // command broadcast
  always_comb begin
    ctl.ins_en = accept && (in_word.opcode == OP_INSERT) && !full;
    ctl.rem_en = accept && (in_word.opcode == OP_REMOVE) && !empty;
  end

  // chain of slots, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          pv, ple, nv;
    logic [PW-1:0] pp, np;
    logic [IW-1:0] pi, ni;
    if (i == 0) begin : g_head
      assign pv  = 1'b1;
      assign ple = 1'b1;
      assign pp  = new_pri;
      assign pi  = new_item;
    end else begin : g_mid
      assign pv  = c_valid[i-1];
      assign ple = c_le[i-1];
      assign pp  = c_pri[i-1];
      assign pi  = c_item[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nv = 1'b0;
      assign np = '0;
      assign ni = '0;
    end else begin : g_body
      assign nv = c_valid[i+1];
      assign np = c_pri[i+1];
      assign ni = c_item[i+1];
    end
    spq_cell #(.PW(PW), .IW(IW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_pri    (new_pri),
      .new_item   (new_item),
      .prev_valid (pv),
      .prev_le    (ple),
      .prev_pri   (pp),
      .prev_item  (pi),
      .next_valid (nv),
      .next_pri   (np),
      .next_item  (ni),
      .valid      (c_valid[i]),
      .le         (c_le[i]),
      .pri        (c_pri[i]),
      .item       (c_item[i])
    );
  end

  // occupancy count and result word
  always_comb begin
    count_nxt = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.rem_en) begin
      count_nxt = count_r - CW'(1);
    end
    out_word_nxt                  = '0;
    out_word_nxt.removed_item     = '0;
    out_word_nxt.removed_priority = '0;
    if (in_word.opcode == OP_INSERT) begin
      out_word_nxt.status = full ? ST_FULL : ST_INSERTED;
    end else if (empty) begin
      out_word_nxt.status = ST_EMPTY;
    end else begin
      out_word_nxt.status           = ST_REMOVED;
      out_word_nxt.removed_item     = ItemFieldW'(c_item[0]);
      out_word_nxt.removed_priority = PriFieldW'(c_pri[0]);
    end
    out_word_nxt.is_empty    = (count_nxt == '0);
    out_word_nxt.entry_count = CountFieldW'(count_nxt);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  // count agrees with the occupied slots
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(c_valid) == int'(count_r))
    else $error("slot count mismatch");

  // occupied slots form a prefix from the head
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid & (c_valid + DEPTH'(1))) == '0)
    else $error("occupied slots not contiguous");

  // accepted remove on a non-empty queue reports the removed status
  a_remove_status: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rem_en |=> (out_valid_r && out_word_r.status == ST_REMOVED))
    else $error("remove not reported");

  // head-to-next ordering of the two front slots
  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid[1] |-> (c_pri[0] <= c_pri[1]))
    else $error("head slots out of order");
`endif

endmodule
